FILE: sv/point_in_mesh_ray_parity_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ray parity block
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_MESH_RAY_PARITY_DEFINES_SVH
`define POINT_IN_MESH_RAY_PARITY_DEFINES_SVH

// Same-cycle implication.
`define PIMR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pimr: same-cycle check failed");

// Next-cycle implication.
`define PIMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pimr: next-cycle check failed");

`endif

FILE: sv/pimr_pkg.sv
// ----------------------------------------------------------------------------
// pimr_pkg
// Types and codes shared by the point-in-mesh ray parity modules.
// ----------------------------------------------------------------------------
package pimr_pkg;

  localparam int unsigned CountW = 11;

  typedef enum logic [1:0] {
    REQ_VERTEX   = 2'd0,
    REQ_TRIANGLE = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    K_VERT  = 2'd0,
    K_TRI   = 2'd1,
    K_QUERY = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_SCAN  = 2'd1,
    B_DRAIN = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         slot;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
  } in_req_t;

  typedef struct packed {
    logic              inside_res;
    logic [CountW-1:0] crossings;
  } out_res_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [9:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [9:0]         ca;
    logic [9:0]         cb;
    logic [9:0]         cc;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vtx_t;

  typedef struct packed {
    logic [9:0] a;
    logic [9:0] b;
    logic [9:0] c;
  } tri_t;

  typedef struct packed {
    logic v;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic scanning;
    logic draining;
  } back_stat_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

FILE: sv/point_in_mesh_ray_parity.sv
// ----------------------------------------------------------------------------
// point_in_mesh_ray_parity
// Point-in-mesh test by counting +x ray crossings against stored triangles.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low. Vertex and triangle
// writes produce no result; a query produces exactly one result, shown on
// out_res for a single cycle with out_strobe high, and the receiver has no way
// to hold it off, so it must take every transfer as it comes. A query walks
// triangles 0 up to triangles_in_use - 1 (clamped to MAX_TRIANGLES) through a
// seven-stage pipeline fed by one triangle-store read per cycle. The back end
// does writes while idle and takes no new command until a query has drained.
// A two-entry command queue decouples request intake from execution; busy
// rises only when that queue is full.
// Stores have no reset: a query that touches a slot never written returns an
// undefined count. The triangles_in_use register is written over the cfg
// channel, which is always ready, and should be changed only while idle.
// ----------------------------------------------------------------------------
module point_in_mesh_ray_parity #(
  parameter int unsigned MAX_VERTICES  = 1024,
  parameter int unsigned MAX_TRIANGLES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pimr_pkg::in_req_t  in_req,
  output logic               out_strobe,
  output pimr_pkg::out_res_t out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_data
);
  import pimr_pkg::*;

`include "point_in_mesh_ray_parity_defines.svh"

  logic [10:0] scan_limit_r;
  logic        push, pop;
  cmd_t        push_cmd, head;
  q_stat_t     q_stat;
  back_stat_t  b_stat;

  // The count register is taken on every cfg transfer.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= '0;
    end else if (cfg_valid) begin
      scan_limit_r <= cfg_data;
    end
  end

  assign busy = q_stat.full;

  pimr_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_front (
    .start (start),
    .q_full(q_stat.full),
    .in_req(in_req),
    .push  (push),
    .cmd   (push_cmd)
  );

  pimr_cmd_q u_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .stat    (q_stat),
    .head    (head)
  );

  pimr_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (head),
    .pop       (pop),
    .scan_limit(scan_limit_r),
    .out_strobe(out_strobe),
    .out_res   (out_res),
    .stat      (b_stat)
  );

  // The inside flag is always the parity of the crossing count.
  `PIMR_ASSERT_NOW(a_parity, out_strobe, out_res.inside_res == out_res.crossings[0])
  // Result strobes never come back to back.
  `PIMR_ASSERT_NEXT(a_no_double, out_strobe, !out_strobe)
  // No result leaves while triangles are still being issued.
  `PIMR_ASSERT_NOW(a_quiet_scan, b_stat.scanning, !out_strobe)

endmodule

FILE: sv/pimr_front.sv
// ----------------------------------------------------------------------------
// pimr_front
// Accepts requests, drops unused codes and out-of-range writes, builds commands.
// ----------------------------------------------------------------------------
module pimr_front #(
  parameter int unsigned MAX_VERTICES  = 1024,
  parameter int unsigned MAX_TRIANGLES = 1024
) (
  input  logic            start,
  input  logic            q_full,
  input  pimr_pkg::in_req_t in_req,
  output logic            push,
  output pimr_pkg::cmd_t  cmd
);
  import pimr_pkg::*;

  logic [31:0] slot32;
  logic        keep;

  assign slot32 = 32'(in_req.slot);

  always_comb begin
    keep     = 1'b0;
    cmd.kind = K_QUERY;
    case (in_req.req_type)
      REQ_VERTEX: begin
        keep     = slot32 < MAX_VERTICES;
        cmd.kind = K_VERT;
      end
      REQ_TRIANGLE: begin
        keep     = slot32 < MAX_TRIANGLES;
        cmd.kind = K_TRI;
      end
      REQ_QUERY: begin
        keep     = 1'b1;
        cmd.kind = K_QUERY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    cmd.slot = in_req.slot;
    cmd.x    = in_req.coord_x;
    cmd.y    = in_req.coord_y;
    cmd.z    = in_req.coord_z;
    cmd.ca   = in_req.corner_a;
    cmd.cb   = in_req.corner_b;
    cmd.cc   = in_req.corner_c;
  end

  assign push = start && !q_full && keep;

endmodule

FILE: sv/pimr_cmd_q.sv
// ----------------------------------------------------------------------------
// pimr_cmd_q
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module pimr_cmd_q (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pimr_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output pimr_pkg::q_stat_t stat,
  output pimr_pkg::cmd_t   head
);
  import pimr_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign do_pop     = pop && (cnt_r != 2'd0);
  assign stat.valid = cnt_r != 2'd0;
  assign stat.full  = cnt_r == 2'd2;
  assign head       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/pimr_back.sv
// ----------------------------------------------------------------------------
// pimr_back
// Executes commands: store writes, and the pipelined triangle scan of a query.
// ----------------------------------------------------------------------------
module pimr_back #(
  parameter int unsigned MAX_VERTICES  = 1024,
  parameter int unsigned MAX_TRIANGLES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pimr_pkg::q_stat_t   q_stat,
  input  pimr_pkg::cmd_t      q_head,
  output logic                pop,
  input  logic [10:0]         scan_limit,
  output logic                out_strobe,
  output pimr_pkg::out_res_t  out_res,
  output pimr_pkg::back_stat_t stat
);
  import pimr_pkg::*;

  localparam int unsigned VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int unsigned NW  = $clog2(MAX_TRIANGLES + 1);

  // Stores: three vertex copies give one read port per corner.
  vtx_t vmem_a [MAX_VERTICES];
  vtx_t vmem_b [MAX_VERTICES];
  vtx_t vmem_c [MAX_VERTICES];
  tri_t tmem   [MAX_TRIANGLES];

  back_state_t st_r, st_nxt;
  logic vwr, twr, start_q, issue, issue_last;

  logic [NW-1:0] n_r, n_nxt, idx_r, idx_nxt;
  vtx_t          org_r;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic          ov_r;
  out_res_t      ores_r;

  ctl_t ctl_r [1:7];

  logic [31:0] slot32, tidx32, ca32, cb32, cc32;

  assign slot32 = 32'(q_head.slot);
  assign tidx32 = 32'(idx_r);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: begin
        if (q_stat.valid && q_head.kind == K_QUERY) begin
          st_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        if (issue_last) begin
          st_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (ctl_r[7].last) begin
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  assign issue_last = (n_r == '0) || (idx_r == n_r - NW'(1));

  // Outputs of the sequencer.
  always_comb begin
    pop     = 1'b0;
    vwr     = 1'b0;
    twr     = 1'b0;
    start_q = 1'b0;
    issue   = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (q_stat.valid) begin
          pop = 1'b1;
          case (q_head.kind)
            K_VERT:  vwr     = 1'b1;
            K_TRI:   twr     = 1'b1;
            K_QUERY: start_q = 1'b1;
            default: pop     = 1'b1;
          endcase
        end
      end
      B_SCAN:  issue = 1'b1;
      B_DRAIN: issue = 1'b0;
      default: issue = 1'b0;
    endcase
  end

  assign stat.scanning = st_r == B_SCAN;
  assign stat.draining = st_r == B_DRAIN;

  always_comb begin
    if (32'(scan_limit) > MAX_TRIANGLES) begin
      n_nxt = NW'(MAX_TRIANGLES);
    end else begin
      n_nxt = NW'(scan_limit);
    end
    idx_nxt = idx_r;
    if (start_q) begin
      idx_nxt = '0;
    end else if (issue) begin
      idx_nxt = idx_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      idx_r <= '0;
      n_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      if (start_q) begin
        n_r <= n_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_q) begin
      org_r <= '{x: q_head.x, y: q_head.y, z: q_head.z};
    end
  end

  // Store writes and reads.
  always_ff @(posedge clk) begin
    if (vwr) begin
      vmem_a[slot32[VAW-1:0]] <= '{x: q_head.x, y: q_head.y, z: q_head.z};
      vmem_b[slot32[VAW-1:0]] <= '{x: q_head.x, y: q_head.y, z: q_head.z};
      vmem_c[slot32[VAW-1:0]] <= '{x: q_head.x, y: q_head.y, z: q_head.z};
    end
    if (twr) begin
      tmem[slot32[TAW-1:0]] <= '{a: q_head.ca, b: q_head.cb, c: q_head.cc};
    end
  end

  // Stage 1: triangle read.
  tri_t tri_r;
  always_ff @(posedge clk) begin
    tri_r <= tmem[tidx32[TAW-1:0]];
  end

  // Stage 2: vertex reads, corners out of range read as the all-zero vertex.
  vtx_t va_r, vb_r, vc_r;
  logic oka_r, okb_r, okc_r;
  assign ca32 = 32'(tri_r.a);
  assign cb32 = 32'(tri_r.b);
  assign cc32 = 32'(tri_r.c);
  always_ff @(posedge clk) begin
    va_r  <= vmem_a[ca32[VAW-1:0]];
    vb_r  <= vmem_b[cb32[VAW-1:0]];
    vc_r  <= vmem_c[cc32[VAW-1:0]];
    oka_r <= ca32 < MAX_VERTICES;
    okb_r <= cb32 < MAX_VERTICES;
    okc_r <= cc32 < MAX_VERTICES;
  end

  // Stage 3: edges and origin offset.
  vtx_t v0, v1, v2;
  logic signed [16:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r, sx_r, sy_r, sz_r;
  always_comb begin
    v0 = oka_r ? va_r : '0;
    v1 = okb_r ? vb_r : '0;
    v2 = okc_r ? vc_r : '0;
  end
  always_ff @(posedge clk) begin
    e1x_r <= 17'(v1.x) - 17'(v0.x);
    e1y_r <= 17'(v1.y) - 17'(v0.y);
    e1z_r <= 17'(v1.z) - 17'(v0.z);
    e2x_r <= 17'(v2.x) - 17'(v0.x);
    e2y_r <= 17'(v2.y) - 17'(v0.y);
    e2z_r <= 17'(v2.z) - 17'(v0.z);
    sx_r  <= 17'(org_r.x) - 17'(v0.x);
    sy_r  <= 17'(org_r.y) - 17'(v0.y);
    sz_r  <= 17'(org_r.z) - 17'(v0.z);
  end

  // Stage 4: cross-product terms.
  logic signed [33:0] pda_r, pdb_r, pua_r, pub_r, pxa_r, pxb_r, pya_r, pyb_r, pza_r, pzb_r;
  logic signed [16:0] f2x_r, f2y_r, f2z_r;
  always_ff @(posedge clk) begin
    pda_r <= 34'(e1z_r) * 34'(e2y_r);
    pdb_r <= 34'(e1y_r) * 34'(e2z_r);
    pua_r <= 34'(sz_r) * 34'(e2y_r);
    pub_r <= 34'(sy_r) * 34'(e2z_r);
    pxa_r <= 34'(sy_r) * 34'(e1z_r);
    pxb_r <= 34'(sz_r) * 34'(e1y_r);
    pya_r <= 34'(sz_r) * 34'(e1x_r);
    pyb_r <= 34'(sx_r) * 34'(e1z_r);
    pza_r <= 34'(sx_r) * 34'(e1y_r);
    pzb_r <= 34'(sy_r) * 34'(e1x_r);
    f2x_r <= e2x_r;
    f2y_r <= e2y_r;
    f2z_r <= e2z_r;
  end

  // Stage 5: det, u, and the q vector.
  logic signed [34:0] det_r, un_r, qx_r, qy_r, qz_r;
  logic signed [16:0] g2x_r, g2y_r, g2z_r;
  always_ff @(posedge clk) begin
    det_r <= 35'(pda_r) - 35'(pdb_r);
    un_r  <= 35'(pua_r) - 35'(pub_r);
    qx_r  <= 35'(pxa_r) - 35'(pxb_r);
    qy_r  <= 35'(pya_r) - 35'(pyb_r);
    qz_r  <= 35'(pza_r) - 35'(pzb_r);
    g2x_r <= f2x_r;
    g2y_r <= f2y_r;
    g2z_r <= f2z_r;
  end

  // Stage 6: t terms and sign normalization of det, u and v.
  logic signed [51:0] tx_r, ty_r, tz_r;
  logic signed [35:0] detn_r, unn_r, vnn_r;
  logic               neg_r;
  always_ff @(posedge clk) begin
    tx_r   <= 52'(g2x_r) * 52'(qx_r);
    ty_r   <= 52'(g2y_r) * 52'(qy_r);
    tz_r   <= 52'(g2z_r) * 52'(qz_r);
    neg_r  <= det_r < 0;
    detn_r <= (det_r < 0) ? -36'(det_r) : 36'(det_r);
    unn_r  <= (det_r < 0) ? -36'(un_r)  : 36'(un_r);
    vnn_r  <= (det_r < 0) ? -36'(qx_r)  : 36'(qx_r);
  end

  // Stage 7: hit decision.
  logic signed [53:0] tn;
  logic signed [54:0] tnn;
  logic signed [36:0] uv;
  logic               hit_r;
  always_comb begin
    tn  = 54'(tx_r) + 54'(ty_r) + 54'(tz_r);
    tnn = neg_r ? -55'(tn) : 55'(tn);
    uv  = 37'(unn_r) + 37'(vnn_r);
  end
  always_ff @(posedge clk) begin
    hit_r <= (detn_r != 0) && (unn_r >= 0) && (unn_r <= detn_r) && (vnn_r >= 0)
             && (uv <= 37'(detn_r)) && (tnn > 0);
  end

  // Control tags travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 7; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[1] <= '{v: issue && (n_r != '0), last: issue && issue_last};
      for (int k = 2; k <= 7; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // Hit counting and result register.
  always_comb begin
    cnt_nxt = cnt_r + CountW'(ctl_r[7].v && hit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      ov_r <= ctl_r[7].last;
      if (start_q) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_r[7].last) begin
      ores_r <= '{inside_res: cnt_nxt[0], crossings: cnt_nxt};
    end
  end

  assign out_strobe = ov_r;
  assign out_res    = ores_r;

endmodule
